// ===== hdl/tpo_pkg.sv =====
// Shared constants, codes and types of the three-phase PWM output stage.
package tpo_pkg;

   // Field widths fixed by the tick format
   localparam int VOLT_W    = 16;
   localparam int BUS_W     = 16;
   localparam int DUTY_W    = 16;
   localparam int CODE_W    = 2;
   localparam int VOLT_MAG_W = VOLT_W - 1;

   // Timer full scale and derived widths
   localparam int FULL_SCALE = 4096;
   localparam int COMPARE_W  = $clog2(FULL_SCALE + 1);
   localparam int DIVIDEND_W = VOLT_MAG_W + COMPARE_W;
   localparam int DUTY_FRAC  = 15;

   // Duty limit register
   localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 16'd31949;
   localparam logic [DUTY_W-1:0] MAX_DUTY_SAT   = 16'd32768;

   // Enable request codes
   localparam logic [CODE_W-1:0] CMD_DISABLE = 2'd0;
   localparam logic [CODE_W-1:0] CMD_ENABLE  = 2'd1;
   localparam logic [CODE_W-1:0] CMD_SHORT   = 2'd2;

   // Output stage codes
   localparam logic [CODE_W-1:0] STAGE_DISABLED = 2'd0;
   localparam logic [CODE_W-1:0] STAGE_ENABLED  = 2'd1;
   localparam logic [CODE_W-1:0] STAGE_SHORT    = 2'd2;

   // Main output enable actions
   localparam logic [CODE_W-1:0] MOE_LEAVE = 2'd0;
   localparam logic [CODE_W-1:0] MOE_CLEAR = 2'd1;
   localparam logic [CODE_W-1:0] MOE_SET   = 2'd2;

   // Control from the sequencer to each divider lane
   typedef struct packed {
      logic load;
      logic step;
   } lane_ctl_type;

endpackage

// ===== hdl/tpo_req_if.sv =====
// Tick request channel: enable command, phase voltages, bus voltage, break status.
interface tpo_req_if;
   logic                                valid;
   logic                                ready;
   logic [tpo_pkg::CODE_W-1:0]          enable_cmd;
   logic signed [tpo_pkg::VOLT_W-1:0]   phase_u_volts;
   logic signed [tpo_pkg::VOLT_W-1:0]   phase_v_volts;
   logic signed [tpo_pkg::VOLT_W-1:0]   phase_w_volts;
   logic [tpo_pkg::BUS_W-1:0]           bus_volts;
   logic                                break_active;

   modport source (
      output valid, enable_cmd, phase_u_volts, phase_v_volts, phase_w_volts,
             bus_volts, break_active,
      input  ready
   );
   modport sink (
      input  valid, enable_cmd, phase_u_volts, phase_v_volts, phase_w_volts,
             bus_volts, break_active,
      output ready
   );
endinterface

// ===== hdl/tpo_rsp_if.sv =====
// Tick response channel: stage state, fault flag, compare values, output action.
interface tpo_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tpo_pkg::CODE_W-1:0]       out_state;
   logic                             fault;
   logic [tpo_pkg::COMPARE_W-1:0]    compare_u;
   logic [tpo_pkg::COMPARE_W-1:0]    compare_v;
   logic [tpo_pkg::COMPARE_W-1:0]    compare_w;
   logic [tpo_pkg::CODE_W-1:0]       main_output_cmd;

   modport source (
      output valid, out_state, fault, compare_u, compare_v, compare_w,
             main_output_cmd,
      input  ready
   );
   modport sink (
      input  valid, out_state, fault, compare_u, compare_v, compare_w,
             main_output_cmd,
      output ready
   );
endinterface

// ===== hdl/tpo_div_lane.sv =====
// Bit-serial restoring divider for one phase, with sign, zero-bus and limit handling.
module tpo_div_lane (
   input  logic                                 clock,
   input  tpo_pkg::lane_ctl_type                ctl,
   input  logic signed [tpo_pkg::VOLT_W-1:0]    volts,
   input  logic [tpo_pkg::BUS_W-1:0]            bus,
   input  logic [tpo_pkg::COMPARE_W-1:0]        limit,
   output logic [tpo_pkg::COMPARE_W-1:0]        result
);

   localparam int DW = tpo_pkg::DIVIDEND_W;

   logic [DW-1:0]               acc_ff, acc_in;
   logic [tpo_pkg::BUS_W-1:0]   rem_ff, rem_in;
   logic [tpo_pkg::BUS_W-1:0]   bus_ff;
   logic                        zero_ff;
   logic                        sat_ff;
   logic [tpo_pkg::BUS_W:0]     trial;
   logic                        fits;
   logic                        positive;

   // Shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial    = {rem_ff, acc_ff[DW-1]};
      fits     = trial >= {1'b0, bus_ff};
      rem_in   = fits ? tpo_pkg::BUS_W'(trial - {1'b0, bus_ff})
                      : trial[tpo_pkg::BUS_W-1:0];
      acc_in   = {acc_ff[DW-2:0], fits};
      positive = !volts[tpo_pkg::VOLT_W-1] && (volts != '0);
   end

   // Load the scaled magnitude at accept, then advance one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_ff  <= DW'(volts[tpo_pkg::VOLT_MAG_W-1:0]) * DW'(tpo_pkg::FULL_SCALE);
         rem_ff  <= '0;
         bus_ff  <= bus;
         zero_ff <= !positive;
         sat_ff  <= positive && (bus == '0);
      end else if (ctl.step) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   // Clamp the quotient to the duty limit
   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (sat_ff || (acc_ff > DW'(limit))) begin
         result = limit;
      end else begin
         result = acc_ff[tpo_pkg::COMPARE_W-1:0];
      end
   end

endmodule

// ===== hdl/three_phase_pwm_output_stage.sv =====
// Top level of the three-phase PWM output stage: tick sequencer, state, lanes, output.
//
// One tick runs from accept to result in three parts: a load of the
// three divider lanes, 28 restoring-division steps (15 magnitude bits of the
// phase voltage plus 13 bits of compare scale, one quotient bit per cycle in
// each lane) and a clamp of the result into the output register. The three
// phases divide side by side. Ticks taken in the disabled or active-short state
// need no division and skip the steps. A new tick is taken as soon as
// the previous one has moved into the output register, even if that result has
// not been collected yet. The duty limit register is written through csr_wr_en
// and csr_wr_data and should change only while no tick is in flight.
module three_phase_pwm_output_stage (
   input  logic                          clock,
   input  logic                          reset,
   tpo_req_if.sink                       req_chan,
   tpo_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [tpo_pkg::DUTY_W-1:0]    csr_wr_data
);

   localparam int CNT_W = $clog2(tpo_pkg::DIVIDEND_W);

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DONE
   } seq_type;

   seq_type                              seq_ff;
   logic [CNT_W-1:0]                     cnt_ff;
   logic [tpo_pkg::DUTY_W-1:0]           max_duty_ff;
   logic [tpo_pkg::CODE_W-1:0]           stage_ff, stage_in;
   logic                                 error_ff, error_in;
   logic                                 calc_ff, calc_in;
   logic [tpo_pkg::CODE_W-1:0]           moe_ff, moe_in;
   logic [tpo_pkg::COMPARE_W-1:0]        limit_ff, limit_in;
   logic [tpo_pkg::DUTY_W-1:0]           duty_sat;
   logic [tpo_pkg::DUTY_W+tpo_pkg::COMPARE_W-1:0] limit_prod;
   logic                                 rsp_valid_ff;
   logic [tpo_pkg::CODE_W-1:0]           rsp_state_ff;
   logic                                 rsp_fault_ff;
   logic [tpo_pkg::COMPARE_W-1:0]        rsp_cu_ff, rsp_cv_ff, rsp_cw_ff;
   logic [tpo_pkg::CODE_W-1:0]           rsp_moe_ff;
   logic [tpo_pkg::COMPARE_W-1:0]        res_u, res_v, res_w;
   logic                                 req_fire;
   logic                                 out_free;
   tpo_pkg::lane_ctl_type                lane_ctl;

   assign req_chan.ready = (seq_ff == SEQ_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign lane_ctl.load = req_fire;
   assign lane_ctl.step = (seq_ff == SEQ_RUN);

   // Decode the next stage, the error latch and the output action at accept
   always_comb begin
      unique case (req_chan.enable_cmd)
         tpo_pkg::CMD_ENABLE: stage_in = tpo_pkg::STAGE_ENABLED;
         tpo_pkg::CMD_SHORT:  stage_in = tpo_pkg::STAGE_SHORT;
         default:             stage_in = tpo_pkg::STAGE_DISABLED;
      endcase
      if ((stage_ff == tpo_pkg::STAGE_ENABLED) || (stage_ff == tpo_pkg::STAGE_SHORT)) begin
         error_in = error_ff || req_chan.break_active;
         calc_in  = (stage_ff == tpo_pkg::STAGE_ENABLED);
         moe_in   = tpo_pkg::MOE_LEAVE;
      end else begin
         error_in = 1'b0;
         calc_in  = 1'b0;
         moe_in   = (stage_in == tpo_pkg::STAGE_DISABLED) ? tpo_pkg::MOE_CLEAR
                                                         : tpo_pkg::MOE_SET;
      end
   end

   // Duty limit in compare counts, saturated at full scale
   always_comb begin
      duty_sat   = (max_duty_ff > tpo_pkg::MAX_DUTY_SAT) ? tpo_pkg::MAX_DUTY_SAT
                                                         : max_duty_ff;
      limit_prod = (tpo_pkg::DUTY_W + tpo_pkg::COMPARE_W)'(duty_sat)
                 * (tpo_pkg::DUTY_W + tpo_pkg::COMPARE_W)'(tpo_pkg::FULL_SCALE);
      limit_in   = limit_prod[tpo_pkg::DUTY_FRAC +: tpo_pkg::COMPARE_W];
   end

   // Hold the duty limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff <= tpo_pkg::MAX_DUTY_RESET;
      end else if (csr_wr_en) begin
         max_duty_ff <= csr_wr_data;
      end
   end

   // One divider lane per phase
   tpo_div_lane u_lane_u (
      .clock  (clock),
      .ctl    (lane_ctl),
      .volts  (req_chan.phase_u_volts),
      .bus    (req_chan.bus_volts),
      .limit  (limit_ff),
      .result (res_u)
   );

   tpo_div_lane u_lane_v (
      .clock  (clock),
      .ctl    (lane_ctl),
      .volts  (req_chan.phase_v_volts),
      .bus    (req_chan.bus_volts),
      .limit  (limit_ff),
      .result (res_v)
   );

   tpo_div_lane u_lane_w (
      .clock  (clock),
      .ctl    (lane_ctl),
      .volts  (req_chan.phase_w_volts),
      .bus    (req_chan.bus_volts),
      .limit  (limit_ff),
      .result (res_w)
   );

   // Sequence the tick, keep the stage state and drive the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         cnt_ff       <= '0;
         stage_ff     <= tpo_pkg::STAGE_DISABLED;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken result beat unless a new one replaces it
         if (rsp_valid_ff && rsp_chan.ready && !((seq_ff == SEQ_DONE) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (seq_ff)
            SEQ_IDLE: begin
               if (req_fire) begin
                  stage_ff <= stage_in;
                  error_ff <= error_in;
                  calc_ff  <= calc_in;
                  moe_ff   <= moe_in;
                  limit_ff <= limit_in;
                  cnt_ff   <= CNT_W'(tpo_pkg::DIVIDEND_W - 1);
                  seq_ff   <= calc_in ? SEQ_RUN : SEQ_DONE;
               end
            end
            SEQ_RUN: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  seq_ff <= SEQ_DONE;
               end
            end
            SEQ_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_state_ff <= stage_ff;
                  rsp_fault_ff <= error_ff;
                  rsp_cu_ff    <= calc_ff ? res_u : '0;
                  rsp_cv_ff    <= calc_ff ? res_v : '0;
                  rsp_cw_ff    <= calc_ff ? res_w : '0;
                  rsp_moe_ff   <= moe_ff;
                  seq_ff       <= SEQ_IDLE;
               end
            end
            default: begin
               seq_ff <= SEQ_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_state       = rsp_state_ff;
   assign rsp_chan.fault           = rsp_fault_ff;
   assign rsp_chan.compare_u       = rsp_cu_ff;
   assign rsp_chan.compare_v       = rsp_cv_ff;
   assign rsp_chan.compare_w       = rsp_cw_ff;
   assign rsp_chan.main_output_cmd = rsp_moe_ff;

   // A tick taken in the disabled state never reports a fault
   a_moe_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.main_output_cmd != tpo_pkg::MOE_LEAVE) |-> !rsp_chan.fault)
      else $error("fault reported on a tick taken in the disabled state");

   // Nonzero compares come only from ticks taken in the enabled state
   a_cmp_leave: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && ((rsp_chan.compare_u != '0) || (rsp_chan.compare_v != '0)
      || (rsp_chan.compare_w != '0)) |-> (rsp_chan.main_output_cmd == tpo_pkg::MOE_LEAVE))
      else $error("nonzero compare with a main output action");

   // Compares never pass the duty limit of the tick
   a_cmp_limit: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_DONE) && out_free |=> (rsp_chan.compare_u <= limit_ff)
      && (rsp_chan.compare_v <= limit_ff) && (rsp_chan.compare_w <= limit_ff))
      else $error("compare above duty limit");

   // An accepted beat closes the request side until its result is out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request taken while a tick is in flight");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the three-phase PWM output stage: random ticks, duty limit sweeps.
module testbench;

   // Unused enable code, treated by the block as a disable request
   localparam logic [tpo_pkg::CODE_W-1:0] CMD_UNUSED = 2'd3;

   // Receiver stall patterns
   localparam logic [1:0] STALL_NONE  = 2'd0;
   localparam logic [1:0] STALL_HALF  = 2'd1;
   localparam logic [1:0] STALL_HEAVY = 2'd2;
   localparam logic [1:0] STALL_LONG  = 2'd3;

   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 244;

   typedef struct packed {
      logic [tpo_pkg::CODE_W-1:0]        cmd;
      logic signed [tpo_pkg::VOLT_W-1:0] u;
      logic signed [tpo_pkg::VOLT_W-1:0] v;
      logic signed [tpo_pkg::VOLT_W-1:0] w;
      logic [tpo_pkg::BUS_W-1:0]         bus;
      logic                              brk;
   } tick_req_type;

   typedef struct packed {
      logic [tpo_pkg::CODE_W-1:0]    state;
      logic                          fault;
      logic [tpo_pkg::COMPARE_W-1:0] cu;
      logic [tpo_pkg::COMPARE_W-1:0] cv;
      logic [tpo_pkg::COMPARE_W-1:0] cw;
      logic [tpo_pkg::CODE_W-1:0]    moe;
   } tick_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en;
   logic [tpo_pkg::DUTY_W-1:0] csr_wr_data;

   tpo_req_if req_chan();
   tpo_rsp_if rsp_chan();

   three_phase_pwm_output_stage dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the block state and duty limit register
   logic [tpo_pkg::CODE_W-1:0] stage_now = tpo_pkg::STAGE_DISABLED;
   logic                       fault_now = 1'b0;
   logic [tpo_pkg::DUTY_W-1:0] duty_reg  = tpo_pkg::MAX_DUTY_RESET;

   tick_req_type pending_ticks[$];
   tick_rsp_type predicted_outputs[$];
   int           fail_count = 0;

   int        burst_left = 0;
   int        gap_left = 0;
   logic [1:0] stall_mode = STALL_NONE;
   int        segment_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Compare value of one phase in the enabled state
   function automatic logic [tpo_pkg::COMPARE_W-1:0] phase_duty(
         logic signed [tpo_pkg::VOLT_W-1:0] volts,
         logic [tpo_pkg::BUS_W-1:0] bus,
         logic [tpo_pkg::COMPARE_W-1:0] limit);
      logic [31:0] quot;
      if (volts <= 0)
         return '0;
      if (bus == '0)
         return limit;
      quot = ({16'd0, volts} * 32'(tpo_pkg::FULL_SCALE)) / {16'd0, bus};
      return (quot > {19'd0, limit}) ? limit : quot[tpo_pkg::COMPARE_W-1:0];
   endfunction

   // Advance the shadow state by one tick and return its outputs
   function automatic tick_rsp_type next_tick_outputs(tick_req_type t);
      tick_rsp_type               r;
      logic [tpo_pkg::CODE_W-1:0] next;
      logic [tpo_pkg::DUTY_W-1:0] duty;
      logic [31:0]                limit;
      duty  = (duty_reg > tpo_pkg::MAX_DUTY_SAT) ? tpo_pkg::MAX_DUTY_SAT : duty_reg;
      limit = ({16'd0, duty} * 32'(tpo_pkg::FULL_SCALE)) >> tpo_pkg::DUTY_FRAC;
      r = '0;
      if (t.cmd == tpo_pkg::CMD_ENABLE)
         next = tpo_pkg::STAGE_ENABLED;
      else if (t.cmd == tpo_pkg::CMD_SHORT)
         next = tpo_pkg::STAGE_SHORT;
      else
         next = tpo_pkg::STAGE_DISABLED;
      if (stage_now == tpo_pkg::STAGE_ENABLED || stage_now == tpo_pkg::STAGE_SHORT) begin
         if (t.brk)
            fault_now = 1'b1;
         if (stage_now == tpo_pkg::STAGE_ENABLED) begin
            r.cu = phase_duty(t.u, t.bus, limit[tpo_pkg::COMPARE_W-1:0]);
            r.cv = phase_duty(t.v, t.bus, limit[tpo_pkg::COMPARE_W-1:0]);
            r.cw = phase_duty(t.w, t.bus, limit[tpo_pkg::COMPARE_W-1:0]);
         end
         r.moe = tpo_pkg::MOE_LEAVE;
      end else begin
         fault_now = 1'b0;
         r.moe = (next == tpo_pkg::STAGE_DISABLED) ? tpo_pkg::MOE_CLEAR : tpo_pkg::MOE_SET;
      end
      stage_now = next;
      r.state = stage_now;
      r.fault = fault_now;
      return r;
   endfunction

   function automatic void queue_tick(logic [tpo_pkg::CODE_W-1:0] cmd,
                                      logic [tpo_pkg::VOLT_W-1:0] u,
                                      logic [tpo_pkg::VOLT_W-1:0] v,
                                      logic [tpo_pkg::VOLT_W-1:0] w,
                                      logic [tpo_pkg::BUS_W-1:0] bus, logic brk);
      tick_req_type t;
      t.cmd = cmd;
      t.u = u;
      t.v = v;
      t.w = w;
      t.bus = bus;
      t.brk = brk;
      pending_ticks.push_back(t);
   endfunction

   // Mix of extremes, values near zero, values scaled to the bus and raw noise
   function automatic logic [tpo_pkg::VOLT_W-1:0] random_volts(
         logic [tpo_pkg::BUS_W-1:0] bus);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1: return tpo_pkg::VOLT_W'($urandom_range(0, 2)) - 16'd1;
         2, 3, 4: return tpo_pkg::VOLT_W'($urandom_range(0, bus)) & 16'h7FFF;
         default: return tpo_pkg::VOLT_W'($urandom());
      endcase
   endfunction

   // Mostly enable requests so the stage stays in the dividing state
   function automatic tick_req_type random_tick();
      tick_req_type t;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         t.cmd = tpo_pkg::CMD_ENABLE;
      else if (pick < 88)
         t.cmd = tpo_pkg::CMD_SHORT;
      else if (pick < 96)
         t.cmd = tpo_pkg::CMD_DISABLE;
      else
         t.cmd = CMD_UNUSED;
      case ($urandom_range(0, 9))
         0: t.bus = '0;
         1, 2: t.bus = tpo_pkg::BUS_W'($urandom_range(1, 255));
         3, 4, 5: t.bus = tpo_pkg::BUS_W'($urandom_range(4096, 16384));
         default: t.bus = tpo_pkg::BUS_W'($urandom());
      endcase
      t.u = random_volts(t.bus);
      t.v = random_volts(t.bus);
      t.w = random_volts(t.bus);
      t.brk = ($urandom_range(0, 3) == 0);
      return t;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Hold until every tick is sent and answered, then let the block go quiet
   task automatic settle();
      while (pending_ticks.size() != 0 || req_chan.valid || predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_duty(input logic [tpo_pkg::DUTY_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      duty_reg = value;
   endtask

   // Sender: predict accepted beats, then offer the next tick in bursts with gaps
   always @(posedge clock) begin : sender
      tick_req_type seen;
      tick_req_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            seen.cmd = req_chan.enable_cmd;
            seen.u = req_chan.phase_u_volts;
            seen.v = req_chan.phase_v_volts;
            seen.w = req_chan.phase_w_volts;
            seen.bus = req_chan.bus_volts;
            seen.brk = req_chan.break_active;
            predicted_outputs.push_back(next_tick_outputs(seen));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               next_item = pending_ticks.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.enable_cmd <= next_item.cmd;
               req_chan.phase_u_volts <= next_item.u;
               req_chan.phase_v_volts <= next_item.v;
               req_chan.phase_w_volts <= next_item.w;
               req_chan.bus_volts <= next_item.bus;
               req_chan.break_active <= next_item.brk;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switch between stall patterns after segments of random length
   always @(posedge clock) begin : receiver
      if (segment_left == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         segment_left <= $urandom_range(20, 200);
      end else begin
         segment_left <= segment_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_chan.ready <= 1'b1;
         STALL_HALF: rsp_chan.ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_chan.ready <= ($urandom_range(0, 19) == 0);
      endcase
   end

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin : monitor
      tick_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_outputs.size() == 0) begin
            $error("result beat with no tick outstanding");
            fail_count++;
         end else begin
            want = predicted_outputs.pop_front();
            check_field("out_state", want.state, rsp_chan.out_state);
            check_field("fault", want.fault, rsp_chan.fault);
            check_field("compare_u", want.cu, rsp_chan.compare_u);
            check_field("compare_v", want.cv, rsp_chan.compare_v);
            check_field("compare_w", want.cw, rsp_chan.compare_w);
            check_field("main_output_cmd", want.moe, rsp_chan.main_output_cmd);
         end
      end
   end

   initial begin : stimulus
      logic [tpo_pkg::DUTY_W-1:0] duty_plan [7];
      req_chan.valid = 1'b0;
      req_chan.enable_cmd = tpo_pkg::CMD_DISABLE;
      req_chan.phase_u_volts = '0;
      req_chan.phase_v_volts = '0;
      req_chan.phase_w_volts = '0;
      req_chan.bus_volts = '0;
      req_chan.break_active = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      duty_plan = '{16'd0, tpo_pkg::MAX_DUTY_SAT, 16'hFFFF, 16'd32767, 16'd8,
                    tpo_pkg::DUTY_W'($urandom_range(0, 65535)), tpo_pkg::MAX_DUTY_RESET};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the states: disabled, enabled, short, back, with break and the unused code
      queue_tick(tpo_pkg::CMD_DISABLE, 16'sd0, 16'sd0, 16'sd0, 16'd4096, 1'b1);
      queue_tick(CMD_UNUSED, 16'sd100, 16'sd100, 16'sd100, 16'd100, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sh7FFF, 16'sh8000, 16'sd0, 16'd1, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd1, -16'sd1, 16'sh7FFF, 16'hFFFF, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd1, 16'sd0, -16'sd5, 16'd0, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd256, 16'sd512, 16'sd1024, 16'd4096, 1'b1);
      queue_tick(tpo_pkg::CMD_SHORT, 16'sd3000, 16'sd2000, 16'sd1000, 16'd4096, 1'b0);
      queue_tick(tpo_pkg::CMD_SHORT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd1, 1'b0);
      queue_tick(CMD_UNUSED, 16'sd500, 16'sd500, 16'sd500, 16'd500, 1'b1);
      queue_tick(tpo_pkg::CMD_SHORT, 16'sd500, 16'sd500, 16'sd500, 16'd500, 1'b1);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd100, 16'sd100, 16'sd100, 16'd100, 1'b1);
      queue_tick(tpo_pkg::CMD_DISABLE, 16'sd100, 16'sd200, 16'sd300, 16'd1000, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
      queue_tick(CMD_UNUSED, 16'sd100, 16'sd99, 16'sd98, 16'd100, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sh8000, 16'sh7FFF, 16'sd1, 16'hFFFF, 1'b0);
      queue_tick(tpo_pkg::CMD_ENABLE, 16'sh7FFF, 16'sd16384, 16'sd8191, 16'd32768, 1'b0);
      queue_tick(tpo_pkg::CMD_DISABLE, 16'sd4096, 16'sd4095, 16'sd1, 16'd4096, 1'b1);
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         pending_ticks.push_back(random_tick());
      settle();

      // Sweep the duty limit, draining the block before each write
      foreach (duty_plan[p]) begin
         write_duty(duty_plan[p]);
         queue_tick(tpo_pkg::CMD_ENABLE, 16'sd100, 16'sd100, 16'sd100, 16'd100, 1'b0);
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            pending_ticks.push_back(random_tick());
         settle();
      end

      if (fail_count == 0 && predicted_outputs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin : watchdog
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
